/* hdl/bts_pkg.sv */
// shared types and constants for the tuple key sorter
`timescale 1ns / 1ps

package bts_pkg;

    // field widths of one tuple
    localparam int FIELD_W = 15;
    localparam int DATA_W  = 32;

    // default block size and depth of the queue between front and back
    localparam int TUPLES_PER_BLOCK_DEF = 7;
    localparam int QUEUE_DEPTH          = 4;

    // one tuple on its way from the front to the back
    typedef struct packed {
        logic                      last;
        logic signed [FIELD_W-1:0] payload;
        logic signed [FIELD_W-1:0] key;
    } tuple_t;

endpackage

/* hdl/bts_front.sv */
// front part: counts tuples and marks the last tuple of each block
`timescale 1ns / 1ps

module bts_front
    import bts_pkg::*;
#(
    parameter int TUPLES_PER_BLOCK = TUPLES_PER_BLOCK_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [FIELD_W-1:0] in_key,
    input  logic signed [FIELD_W-1:0] in_payload,
    output logic                      push_valid,
    input  logic                      push_ready,
    output tuple_t                    push_data
);

    localparam int CW = $clog2(TUPLES_PER_BLOCK);

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          block_last;
    logic          xfer;

    // pass the handshake straight to the queue
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign xfer       = in_valid && push_ready;
    assign block_last = (fill_reg == CW'(TUPLES_PER_BLOCK - 1));

    // tag the tuple
    always_comb
    begin
        push_data.key     = in_key;
        push_data.payload = in_payload;
        push_data.last    = block_last;
    end

    // fill count wraps at the end of each block
    always_comb
    begin
        fill_next = fill_reg;
        if (xfer)
        begin
            fill_next = block_last ? '0 : fill_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

/* hdl/bts_queue.sv */
// short tuple queue between front and back
`timescale 1ns / 1ps

module bts_queue
    import bts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  tuple_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output tuple_t pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    tuple_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/bts_back.sv */
// back part: row of cells that loads a block, sorts it and streams it out
`timescale 1ns / 1ps

module bts_back
    import bts_pkg::*;
#(
    parameter int TUPLES_PER_BLOCK = TUPLES_PER_BLOCK_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  tuple_t                    pop_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [FIELD_W-1:0] out_key,
    output logic signed [FIELD_W-1:0] out_payload,
    output logic                      out_last
);

    localparam int N  = TUPLES_PER_BLOCK;
    localparam int CW = $clog2(N);

    typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_OUT} state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [FIELD_W-1:0] out_key_reg;
    logic signed [FIELD_W-1:0] out_key_next;
    logic signed [FIELD_W-1:0] out_payload_reg;
    logic signed [FIELD_W-1:0] out_payload_next;
    logic                      out_last_reg;
    logic                      out_last_next;

    logic signed [FIELD_W-1:0] key_reg  [N];
    logic signed [FIELD_W-1:0] key_next [N];
    logic signed [FIELD_W-1:0] pay_reg  [N];
    logic signed [FIELD_W-1:0] pay_next [N];

    logic do_pop;
    logic out_load;
    logic cnt_end;

    assign pop_ready   = (state_reg == ST_LOAD);
    assign do_pop      = pop_valid && pop_ready;
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign cnt_end     = (cnt_reg == CW'(N - 1));
    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign out_last    = out_last_reg;

    // cell row: shift in on load, odd-even exchange on sort, shift out on unload
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            key_next[i] = key_reg[i];
            pay_next[i] = pay_reg[i];
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (do_pop)
                begin
                    for (int i = 0; i < N - 1; i++)
                    begin
                        key_next[i] = key_reg[i+1];
                        pay_next[i] = pay_reg[i+1];
                    end
                    key_next[N-1] = pop_data.key;
                    pay_next[N-1] = pop_data.payload;
                end
            end
            ST_SORT:
            begin
                // strict compare keeps equal keys in arrival order
                for (int i = 0; i < N - 1; i++)
                begin
                    if (((i % 2) == 1) == cnt_reg[0] && key_reg[i] > key_reg[i+1])
                    begin
                        key_next[i]   = key_reg[i+1];
                        pay_next[i]   = pay_reg[i+1];
                        key_next[i+1] = key_reg[i];
                        pay_next[i+1] = pay_reg[i];
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    for (int i = 0; i < N - 1; i++)
                    begin
                        key_next[i] = key_reg[i+1];
                        pay_next[i] = pay_reg[i+1];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            key_reg[i] <= key_next[i];
            pay_reg[i] <= pay_next[i];
        end
    end

    // sequencer and output register
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        out_key_next     = out_key_reg;
        out_payload_next = out_payload_reg;
        out_last_next    = out_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (do_pop && pop_data.last)
                begin
                    state_next = ST_SORT;
                    cnt_next   = '0;
                end
            end
            ST_SORT:
            begin
                if (cnt_end)
                begin
                    state_next = ST_OUT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    out_key_next     = key_reg[0];
                    out_payload_next = pay_reg[0];
                    out_last_next    = cnt_end;
                    if (cnt_end)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_key_reg     <= '0;
            out_payload_reg <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            out_key_reg     <= out_key_next;
            out_payload_reg <= out_payload_next;
            out_last_reg    <= out_last_next;
        end
    end

endmodule

/* hdl/block_tuple_key_sorter.sv */
// Stable key sorter for blocks of TUPLES_PER_BLOCK tuples.
//
// Input stream s_*: one tuple per transfer (key and payload in s_tdata).
// Output stream m_*: the same tuples in ascending key order, tuples with
// equal keys in arrival order; m_tlast is high on the last tuple of a block.
// A front part counts the tuples of a block and tags the last one, a
// four-entry queue decouples it from the back part, and the back part holds
// the block in a row of N cells that load, sort and unload in turn.
// Input: one tuple per cycle while the queue has room and the back loads.
// Sorting is odd-even neighbor exchange in the cell row. Once a block is
// loaded and sorted, m_tvalid rises, then one result per cycle while
// m_tready is high. The single cell row loads, sorts and unloads one
// block before it takes the tuples of the next block.
// When the receiver stalls, the output register holds its result and the
// cells hold the rest; the queue fills and s_tready falls.
// Reset empties the queue and drops any partly gathered block.
`timescale 1ns / 1ps

module block_tuple_key_sorter
    import bts_pkg::*;
#(
    parameter int TUPLES_PER_BLOCK = TUPLES_PER_BLOCK_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,  // tuple_key[14:0], tuple_payload[29:15], zero pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,  // sorted_key[14:0], sorted_payload[29:15], zero pad
    output logic              m_tlast
);

    logic                      push_valid;
    logic                      push_ready;
    tuple_t                    push_data;
    logic                      pop_valid;
    logic                      pop_ready;
    tuple_t                    pop_data;
    logic signed [FIELD_W-1:0] out_key;
    logic signed [FIELD_W-1:0] out_payload;

    // tuple counting and block tagging
    bts_front #(
        .TUPLES_PER_BLOCK (TUPLES_PER_BLOCK)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_key     (s_tdata[FIELD_W-1:0]),
        .in_payload (s_tdata[2*FIELD_W-1:FIELD_W]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    bts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // sorting cell row and output register
    bts_back #(
        .TUPLES_PER_BLOCK (TUPLES_PER_BLOCK)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_key     (out_key),
        .out_payload (out_payload),
        .out_last    (m_tlast)
    );

    // pack the output fields
    assign m_tdata = {(DATA_W - 2 * FIELD_W)'(0), out_payload, out_key};

endmodule

/* bench/block_tuple_key_sorter_tb.sv */
// self-checking bench for the stable block tuple key sorter
`timescale 1ns / 1ps

module block_tuple_key_sorter_tb;
    import bts_pkg::*;

    localparam int BLOCK_LEN    = TUPLES_PER_BLOCK_DEF;
    localparam int RANDOM_BLKS  = 49;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    typedef logic signed [FIELD_W-1:0] field_t;

    // key patterns used for the random blocks
    typedef enum int {
        KEYS_FULL,
        KEYS_FEW,
        KEYS_RANGE,
        KEYS_ASCENDING
    } key_mode_t;

    // holds the tuples of the current block and the sorted tuples still owed
    class sorted_tuple_board;
        field_t block_key [BLOCK_LEN];
        field_t block_payload [BLOCK_LEN];
        int     held;
        field_t want_key [$];
        field_t want_payload [$];
        logic   want_last [$];
        int     errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return want_key.size();
        endfunction

        task report(input string what, input int got, input int want);
            if (errors < PRINT_CAP)
                $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                         want);
            errors++;
        endtask

        // gather one transfer; a full block is sorted stably and queued
        function void note_tuple(input field_t key, input field_t payload);
            field_t tk;
            field_t tp;
            block_key[held]     = key;
            block_payload[held] = payload;
            held++;
            if (held == BLOCK_LEN)
            begin
                // neighbor swap only on strictly greater keys keeps equal keys in order
                for (int pass = 0; pass < BLOCK_LEN - 1; pass++)
                begin
                    for (int pos = 0; pos < BLOCK_LEN - 1 - pass; pos++)
                    begin
                        if (block_key[pos] > block_key[pos+1])
                        begin
                            tk                   = block_key[pos];
                            tp                   = block_payload[pos];
                            block_key[pos]       = block_key[pos+1];
                            block_payload[pos]   = block_payload[pos+1];
                            block_key[pos+1]     = tk;
                            block_payload[pos+1] = tp;
                        end
                    end
                end
                for (int i = 0; i < BLOCK_LEN; i++)
                begin
                    want_key.push_back(block_key[i]);
                    want_payload.push_back(block_payload[i]);
                    want_last.push_back(i == BLOCK_LEN - 1);
                end
                held = 0;
            end
        endfunction

        // compare one output transfer with the oldest owed tuple
        task check_tuple(input field_t key, input field_t payload, input logic last);
            field_t wk;
            field_t wp;
            logic   wl;
            if (want_key.size() == 0)
            begin
                report("unexpected output transfer key", key, 0);
            end
            else
            begin
                wk = want_key.pop_front();
                wp = want_payload.pop_front();
                wl = want_last.pop_front();
                if (key !== wk)
                    report("sorted_key", key, wk);
                if (payload !== wp)
                    report("sorted_payload", payload, wp);
                if (last !== wl)
                    report("block_end", last, wl);
            end
        endtask
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    sorted_tuple_board board;
    bit                s_calm = 1'b0;
    bit                m_calm = 1'b0;
    int                cycles = 0;

    block_tuple_key_sorter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int idle_cycles(input bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // one input transfer, after a random idle gap when s_calm is clear
    task automatic send_tuple(input field_t key, input field_t payload);
        int gap;
        gap = idle_cycles(s_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - 2*FIELD_W){1'b0}}, payload, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_tuple(key, payload);
    endtask

    // one random block with the given key pattern
    task automatic send_random_block(input key_mode_t mode);
        field_t key;
        field_t payload;
        int     base;
        base = $urandom_range(0, 1000);
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            case (mode)
                KEYS_FULL:      key = field_t'($urandom);
                KEYS_FEW:       key = field_t'($urandom_range(0, 3) - 2);
                KEYS_RANGE:     key = field_t'($urandom_range(0, 10998) - 999);
                default:        key = field_t'(base - 999 + i * $urandom_range(0, 2));
            endcase
            payload = ($urandom_range(0, 3) == 0) ? field_t'($urandom_range(0, 10998) - 999)
                                                  : field_t'($urandom);
            send_tuple(key, payload);
        end
    endtask

    // receiver: random ready gaps, checks every output transfer
    task automatic take_results();
        int gap;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                m_calm = !m_calm;
            gap = idle_cycles(m_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            board.check_tuple(field_t'(m_tdata[FIELD_W-1:0]),
                              field_t'(m_tdata[2*FIELD_W-1:FIELD_W]), m_tlast);
        end
    endtask

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            take_results();
        join_none

        // extremes of both fields, equal extreme keys in two places
        send_tuple(field_t'(16383), field_t'(-16384));
        send_tuple(field_t'(-16384), field_t'(16383));
        send_tuple(field_t'(0), field_t'(15'h2aaa));
        send_tuple(field_t'(-1), field_t'(15'h5555));
        send_tuple(field_t'(16383), field_t'(0));
        send_tuple(field_t'(-16384), field_t'(-1));
        send_tuple(field_t'(1), field_t'(1));

        // all keys equal, arrival order must survive
        s_calm = 1'b1;
        for (int i = 0; i < BLOCK_LEN; i++)
            send_tuple(field_t'(5), field_t'(i));

        // strictly descending keys across the stated range
        s_calm = 1'b0;
        for (int i = 0; i < BLOCK_LEN; i++)
            send_tuple(field_t'(9999 - i * 1833), field_t'(-999 + i));

        // random blocks, some with no input gaps
        for (int b = 0; b < RANDOM_BLKS; b++)
        begin
            s_calm = ($urandom_range(0, 3) == 0);
            send_random_block(key_mode_t'($urandom_range(0, 3)));
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray outputs
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
